[rtl/dpit_pkg.sv]
// Package for the dual prescaled interval timer.
// Holds operation codes, widths, reset constants, the timer command struct and the
// reload product function. It depends on nothing else.
`default_nettype none

package dpit_pkg;

   localparam int OP_W     = 3;
   localparam int OFFSET_W = 3;
   localparam int DATA_W   = 16;
   localparam int CYCLES_W = 10;
   localparam int COUNT_W  = 2 * (DATA_W + 1) - 1;

   localparam logic [DATA_W-1:0]  REG_RESET   = 16'hFFFF;
   localparam logic [7:0]         BYTE_MASK   = 8'hFF;
   localparam logic [COUNT_W-1:0] RELOAD_MAX  = 33'h1_0000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 3'd0,
      OP_BYTE_WRITE = 3'd1,
      OP_WORD_WRITE = 3'd2,
      OP_BYTE_READ  = 3'd3,
      OP_WORD_READ  = 3'd4
   } op_type;

   typedef struct packed {
      logic                tick;
      logic                wr_en;
      logic                wr_div;
      logic                wr_hi;
      logic                wr_lo;
      logic [DATA_W-1:0]   data;
      logic [CYCLES_W-1:0] cycles;
   } tmr_cmd_type;

   function automatic logic [COUNT_W-1:0] reload_value(input logic [DATA_W-1:0] pre,
                                                       input logic [DATA_W-1:0] div);
      logic [2*DATA_W+1:0] prod;
      prod = ({1'b0, pre} + 17'd1) * ({1'b0, div} + 17'd1);
      if (pre == '0 || div == '0) begin
         return '0;
      end
      return prod[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/dpit_timer.sv]
// One interval timer: prescaler and divider registers and the down counter.
// Depends on dpit_pkg for the command struct and the reload product.
`default_nettype none

module dpit_timer
   import dpit_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tmr_cmd_type       cmd,
   output logic [DATA_W-1:0]      prescale,
   output logic [DATA_W-1:0]      divide,
   output logic                   fire
);

   logic [DATA_W-1:0]  prescale_ff, prescale_in;
   logic [DATA_W-1:0]  divide_ff, divide_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0]  merged;
   logic [DATA_W-1:0]  target;
   logic [COUNT_W-1:0] reload;
   logic [COUNT_W-1:0] cycles_ext;

   assign target = cmd.wr_div ? divide_ff : prescale_ff;

   always_comb begin
      merged[15:8] = cmd.wr_hi ? cmd.data[15:8] : target[15:8];
      merged[7:0]  = cmd.wr_lo ? cmd.data[7:0] : target[7:0];
      prescale_in  = prescale_ff;
      divide_in    = divide_ff;
      if (cmd.wr_en && cmd.wr_div) begin
         divide_in = merged;
      end else if (cmd.wr_en) begin
         prescale_in = merged;
      end
   end

   assign reload     = reload_value(prescale_in, divide_in);
   assign cycles_ext = {{(COUNT_W-CYCLES_W){1'b0}}, cmd.cycles};
   assign fire       = cmd.tick && (count_ff == '0 || count_ff <= cycles_ext);

   always_comb begin
      count_in = count_ff;
      if (cmd.wr_en || fire) begin
         count_in = reload;
      end else if (cmd.tick) begin
         count_in = count_ff - cycles_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= REG_RESET;
         divide_ff   <= REG_RESET;
         count_ff    <= '0;
      end else begin
         prescale_ff <= prescale_in;
         divide_ff   <= divide_in;
         count_ff    <= count_in;
      end
   end

   assign prescale = prescale_ff;
   assign divide   = divide_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RELOAD_MAX)
      else $error("Timer count exceeds the largest reload value.");

   a_zero_fires: assert property (@(posedge clock) disable iff (reset)
      cmd.tick && count_ff == '0 |-> fire)
      else $error("A zero counter did not fire on a tick.");

   a_fire_reloads: assert property (@(posedge clock) disable iff (reset)
      fire && !cmd.wr_en |=> count_ff == reload_value(prescale_ff, divide_ff))
      else $error("A firing timer did not reload.");

endmodule

`default_nettype wire

[rtl/dual_prescaled_interval_timer_unit.sv]
// Top level of the dual prescaled interval timer: input register, decode, read
// mux and result register around two dpit_timer instances. Depends on dpit_pkg.
//
//   Channel   Direction   Handshake           Payload
//   req_      in          req_valid/stall     op, reg_offset, write_value, tick_cycles
//   rsp_      out         rsp_valid/stall     read_value, irq_timer_one, irq_timer_two
//
// An item is accepted every cycle while req_stall is low; it moves from input to result register.
// The input register and the result register bound a single pass through the decode,
// the 17-by-17 reload multiplier and the counter subtract.
// Reset is synchronous: registers return to 0xFFFF, counters to zero, no item is held.
// A stalled result holds both stages; req_stall rises only then.
`default_nettype none

module dual_prescaled_interval_timer_unit
   import dpit_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [OFFSET_W-1:0] req_reg_offset,
   input  wire logic [DATA_W-1:0]   req_write_value,
   input  wire logic [CYCLES_W-1:0] req_tick_cycles,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [DATA_W-1:0]        rsp_read_value,
   output logic                     rsp_irq_timer_one,
   output logic                     rsp_irq_timer_two
);

   logic                in_valid_ff, in_valid_in;
   logic [OP_W-1:0]     op_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [DATA_W-1:0]   wdata_ff;
   logic [CYCLES_W-1:0] cycles_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   read_ff, read_in;
   logic                irq_one_ff, irq_one_in;
   logic                irq_two_ff, irq_two_in;

   logic                advance;
   logic                go;
   logic                high;
   logic [1:0]          idx;
   logic [DATA_W-1:0]   slot;
   tmr_cmd_type         cmd_one, cmd_two, cmd;
   logic                wr_any;
   logic [DATA_W-1:0]   pre_one, div_one, pre_two, div_two;
   logic                fire_one, fire_two;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign go        = in_valid_ff && advance;
   assign idx       = offset_ff[2:1];
   assign high      = !offset_ff[0];

   always_comb begin
      unique case (idx)
         2'd0:    slot = pre_one;
         2'd1:    slot = div_one;
         2'd2:    slot = pre_two;
         default: slot = div_two;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.cycles = cycles_ff;
      cmd.wr_div = idx[0];
      wr_any     = 1'b0;
      read_in    = '0;
      unique case (op_ff)
         OP_TICK: begin
            cmd.tick = go;
         end
         OP_BYTE_WRITE: begin
            wr_any    = go;
            cmd.wr_hi = high;
            cmd.wr_lo = !high;
            cmd.data  = {wdata_ff[7:0], wdata_ff[7:0]};
         end
         OP_WORD_WRITE: begin
            wr_any    = go && high;
            cmd.wr_hi = 1'b1;
            cmd.wr_lo = 1'b1;
            cmd.data  = wdata_ff;
         end
         OP_BYTE_READ: begin
            read_in = high ? {8'h00, slot[15:8]} : {8'h00, slot[7:0] & BYTE_MASK};
         end
         OP_WORD_READ: begin
            read_in = high ? slot : '0;
         end
         default: begin
            read_in = '0;
         end
      endcase
      cmd_one       = cmd;
      cmd_two       = cmd;
      cmd_one.wr_en = wr_any && !idx[1];
      cmd_two.wr_en = wr_any && idx[1];
   end

   dpit_timer u_timer_one (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_one),
      .prescale (pre_one),
      .divide   (div_one),
      .fire     (fire_one)
   );

   dpit_timer u_timer_two (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_two),
      .prescale (pre_two),
      .divide   (div_two),
      .fire     (fire_two)
   );

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   assign irq_one_in   = fire_one;
   assign irq_two_in   = fire_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff     <= req_op;
         offset_ff <= req_reg_offset;
         wdata_ff  <= req_write_value;
         cycles_ff <= req_tick_cycles;
      end
      if (go) begin
         read_ff    <= read_in;
         irq_one_ff <= irq_one_in;
         irq_two_ff <= irq_two_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = read_ff;
   assign rsp_irq_timer_one = irq_one_ff;
   assign rsp_irq_timer_two = irq_two_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("Input stalled while the result stage could move.");

   a_irq_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_irq_timer_one || rsp_irq_timer_two) |-> rsp_read_value == '0)
      else $error("A result carries both read data and an interrupt.");

   a_item_reaches_result: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("An item left the input stage without a result.");

endmodule

`default_nettype wire

[test/dual_prescaled_interval_timer_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dual_prescaled_interval_timer_unit: directed and random register
// accesses and ticks are predicted by a local model of both timers and checked per result.
// Depends on dpit_pkg and the RTL of the unit.

module dual_prescaled_interval_timer_unit_tb
   import dpit_pkg::*;
();

   localparam int RANDOM_ITEMS    = 2000;
   localparam int QUIET_TAIL      = 150;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 1000;

   localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

   localparam logic [OFFSET_W-1:0] PRESCALE_ONE_HI = 3'd0;
   localparam logic [OFFSET_W-1:0] DIVIDE_ONE_HI   = 3'd2;
   localparam logic [OFFSET_W-1:0] DIVIDE_ONE_LO   = 3'd3;
   localparam logic [OFFSET_W-1:0] PRESCALE_TWO_HI = 3'd4;
   localparam logic [OFFSET_W-1:0] PRESCALE_TWO_LO = 3'd5;
   localparam logic [OFFSET_W-1:0] DIVIDE_TWO_HI   = 3'd6;
   localparam logic [OFFSET_W-1:0] DIVIDE_TWO_LO   = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   value;
      logic [CYCLES_W-1:0] cycles;
   } timer_access_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              irq_one;
      logic              irq_two;
   } timer_result_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op          = '0;
   logic [OFFSET_W-1:0] req_reg_offset  = '0;
   logic [DATA_W-1:0]   req_write_value = '0;
   logic [CYCLES_W-1:0] req_tick_cycles = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [DATA_W-1:0]   rsp_read_value;
   logic                rsp_irq_timer_one;
   logic                rsp_irq_timer_two;

   timer_access_type   pending_items[$];
   timer_result_type   expected_results[$];
   timer_access_type   outgoing;
   logic [DATA_W-1:0]  timer_regs [4];
   logic signed [33:0] countdown [2];

   int   total_items;
   int   requests_taken = 0;
   int   mismatches     = 0;
   int   idle_cycles    = 0;
   int   cycle_count    = 0;
   int   send_gap       = 0;
   int   stall_left     = 0;
   int   hold_left      = 0;
   logic hold_done      = 1'b0;
   logic req_taken      = 1'b0;
   logic calm;

   assign calm = (cycle_count % 1024) < 200;

   dual_prescaled_interval_timer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_reg_offset    (req_reg_offset),
      .req_write_value   (req_write_value),
      .req_tick_cycles   (req_tick_cycles),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_value    (rsp_read_value),
      .rsp_irq_timer_one (rsp_irq_timer_one),
      .rsp_irq_timer_two (rsp_irq_timer_two)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic signed [33:0] period_of(input logic [DATA_W-1:0] pre,
                                                    input logic [DATA_W-1:0] div);
      if (pre == '0 || div == '0) begin
         return '0;
      end
      return $signed((34'(pre) + 34'd1) * (34'(div) + 34'd1));
   endfunction

   task automatic advance_timer(input int t, input logic [CYCLES_W-1:0] cycles,
                                output logic fired);
      if (countdown[t] != 0) begin
         countdown[t] = countdown[t] - $signed({24'd0, cycles});
      end
      fired = countdown[t] <= 0;
      if (fired) begin
         countdown[t] = period_of(timer_regs[2*t], timer_regs[2*t+1]);
      end
   endtask

   task automatic predict_result(input logic [OP_W-1:0] op, input logic [OFFSET_W-1:0] offset,
                                 input logic [DATA_W-1:0] value,
                                 input logic [CYCLES_W-1:0] cycles);
      timer_result_type res;
      logic [1:0]       idx;
      logic             high;
      logic             fired_one;
      logic             fired_two;
      res  = '0;
      idx  = offset[2:1];
      high = !offset[0];
      case (op)
         OP_TICK: begin
            advance_timer(0, cycles, fired_one);
            advance_timer(1, cycles, fired_two);
            res.irq_one = fired_one;
            res.irq_two = fired_two;
         end
         OP_BYTE_WRITE: begin
            if (high) begin
               timer_regs[idx][15:8] = value[7:0];
            end else begin
               timer_regs[idx][7:0] = value[7:0];
            end
            countdown[idx[1]] = period_of(timer_regs[{idx[1], 1'b0}],
                                          timer_regs[{idx[1], 1'b1}]);
         end
         OP_WORD_WRITE: begin
            if (high) begin
               timer_regs[idx] = value;
               countdown[idx[1]] = period_of(timer_regs[{idx[1], 1'b0}],
                                             timer_regs[{idx[1], 1'b1}]);
            end
         end
         OP_BYTE_READ: begin
            res.read_value = high ? {8'd0, timer_regs[idx][15:8]} : {8'd0, timer_regs[idx][7:0]};
         end
         OP_WORD_READ: begin
            if (high) begin
               res.read_value = timer_regs[idx];
            end
         end
         default: begin
         end
      endcase
      expected_results.push_back(res);
   endtask

   task automatic check_result();
      timer_result_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected item read_value %h irq_one %b irq_two %b", $time,
                  rsp_read_value, rsp_irq_timer_one, rsp_irq_timer_two);
         mismatches++;
      end else begin
         want = expected_results.pop_front();
         if (rsp_read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     rsp_read_value);
            mismatches++;
         end
         if (rsp_irq_timer_one !== want.irq_one) begin
            $display("%0t: irq_timer_one expected %b actual %b", $time, want.irq_one,
                     rsp_irq_timer_one);
            mismatches++;
         end
         if (rsp_irq_timer_two !== want.irq_two) begin
            $display("%0t: irq_timer_two expected %b actual %b", $time, want.irq_two,
                     rsp_irq_timer_two);
            mismatches++;
         end
      end
   endtask

   task automatic add_item(input logic [OP_W-1:0] op, input logic [OFFSET_W-1:0] offset,
                           input logic [DATA_W-1:0] value, input logic [CYCLES_W-1:0] cycles);
      timer_access_type it;
      it.op     = op;
      it.offset = offset;
      it.value  = value;
      it.cycles = cycles;
      pending_items.push_back(it);
   endtask

   function automatic timer_access_type random_access();
      timer_access_type it;
      int               pick;
      pick      = $urandom_range(0, 99);
      it.offset = OFFSET_W'($urandom_range(0, 7));
      it.value  = ($urandom_range(0, 9) < 7) ? DATA_W'($urandom_range(0, 7)) : DATA_W'($urandom);
      it.cycles = ($urandom_range(0, 1) == 0) ? CYCLES_W'($urandom_range(0, 15))
                                              : CYCLES_W'($urandom);
      if (pick < 45) begin
         it.op = OP_TICK;
      end else if (pick < 63) begin
         it.op = OP_BYTE_WRITE;
      end else if (pick < 73) begin
         it.op = OP_WORD_WRITE;
      end else if (pick < 82) begin
         it.op = OP_BYTE_READ;
      end else if (pick < 93) begin
         it.op = OP_WORD_READ;
      end else begin
         it.op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end
      return it;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            outgoing = pending_items.pop_front();
            req_op          <= outgoing.op;
            req_reg_offset  <= outgoing.offset;
            req_write_value <= outgoing.value;
            req_tick_cycles <= outgoing.cycles;
            req_valid       <= 1'b1;
            if (!calm && pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && requests_taken >= HOLD_OFF_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_result(req_op, req_reg_offset, req_write_value, req_tick_cycles);
            requests_taken <= requests_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      for (int i = 0; i < 4; i++) begin
         timer_regs[i] = REG_RESET;
      end
      countdown[0] = '0;
      countdown[1] = '0;

      // Reads of the reset values, including an odd word read.
      add_item(OP_WORD_READ, PRESCALE_ONE_HI, '0, '0);
      add_item(OP_BYTE_READ, DIVIDE_ONE_HI, '1, '1);
      add_item(OP_BYTE_READ, DIVIDE_TWO_LO, '0, '0);
      add_item(OP_WORD_READ, DIVIDE_ONE_LO, '1, '1);
      // Both counters start at zero, so the first tick fires both and loads the largest period.
      add_item(OP_TICK, PRESCALE_ONE_HI, '1, '0);
      add_item(OP_TICK, DIVIDE_TWO_LO, '0, '1);
      // Timer one gets a period of six; an odd word write must be ignored.
      add_item(OP_WORD_WRITE, PRESCALE_ONE_HI, 16'd1, '1);
      add_item(OP_WORD_WRITE, DIVIDE_ONE_HI, 16'd2, '0);
      add_item(OP_WORD_WRITE, DIVIDE_ONE_LO, '1, '0);
      add_item(OP_WORD_READ, DIVIDE_ONE_HI, '0, '0);
      add_item(OP_TICK, DIVIDE_ONE_LO, '0, 10'd0);
      add_item(OP_TICK, DIVIDE_ONE_LO, '0, 10'd5);
      add_item(OP_TICK, DIVIDE_ONE_LO, '0, 10'd1);
      add_item(OP_TICK, DIVIDE_ONE_LO, '0, '1);
      // Byte writes clear prescale_two, so timer two fires on every tick.
      add_item(OP_BYTE_WRITE, PRESCALE_TWO_LO, 16'hA500, '0);
      add_item(OP_BYTE_WRITE, PRESCALE_TWO_HI, 16'hFF00, '1);
      add_item(OP_BYTE_READ, PRESCALE_TWO_LO, '1, '0);
      add_item(OP_TICK, PRESCALE_TWO_HI, '1, 10'd0);
      add_item(OP_TICK, PRESCALE_TWO_HI, '1, 10'd3);
      add_item(OP_RESERVED_LO, PRESCALE_ONE_HI, '1, '1);
      add_item(OP_RESERVED_HI, DIVIDE_TWO_LO, '1, '1);
      // A zero divider also gives a zero period; then the largest period again.
      add_item(OP_WORD_WRITE, DIVIDE_TWO_HI, '0, '0);
      add_item(OP_WORD_WRITE, PRESCALE_TWO_HI, '1, '0);
      add_item(OP_TICK, DIVIDE_TWO_HI, '0, 10'd2);
      add_item(OP_WORD_WRITE, DIVIDE_TWO_HI, '1, '0);
      add_item(OP_TICK, DIVIDE_TWO_HI, '0, '1);

      repeat (RANDOM_ITEMS) begin
         pending_items.push_back(random_access());
      end
      total_items = pending_items.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (requests_taken < total_items || expected_results.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
